/* rtl/sth_pkg.sv */
// ----------------------------------------------------------------------------
// sth_pkg
// shared types, constants and the siphash round function for the tree hash core
// ----------------------------------------------------------------------------
package sth_pkg;

    // lane count and word sizes
    localparam int LANES      = 4;
    localparam int WORD_W     = 64;
    localparam int TAIL_W     = 5;
    localparam int PKT_BYTES  = LANES * WORD_W / 8;
    localparam int CFG_IDX_W  = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = CFG_IDX_W'(3);

    // lane i is keyed with key word xor (base + i)
    localparam int KEY_TWEAK_BASE = 4;

    // state initialization constants
    localparam logic [WORD_W-1:0] INIT_C0 = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] INIT_C1 = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] INIT_C2 = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] INIT_C3 = 64'h7465646279746573;

    // finalization marker xored into v2
    localparam logic [WORD_W-1:0] FINAL_MARK = 64'h00000000000000ff;

    // round schedule: rounds per packet and extra rounds at finalization
    localparam int ABSORB_ROUNDS = 2;
    localparam int FINAL_ROUNDS  = 4;
    localparam int RND_W         = $clog2(ABSORB_ROUNDS + FINAL_ROUNDS);

    // rotation amounts of one round
    localparam int ROT_B1 = 13;
    localparam int ROT_D1 = 16;
    localparam int ROT_HALF = 32;
    localparam int ROT_B2 = 17;
    localparam int ROT_D2 = 21;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [LANES-1:0][WORD_W-1:0] t_packet;

    typedef struct packed {
        t_word v0;
        t_word v1;
        t_word v2;
        t_word v3;
    } t_sip_state;

    // per-cycle commands from the sequencer to every lane
    typedef struct packed {
        logic init;     // reload state from the lane key
        logic start;    // first round of a packet, v3 takes the word
        logic step;     // a later round on the held state
        logic mix;      // v0 takes the word after this round
        logic mark;     // v2 takes the finalization marker after this round
    } t_lane_ctrl;

    function automatic t_word rotl(input t_word x, input int n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

    // one siprounds pass
    function automatic t_sip_state sip_round(input t_sip_state s);
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        a = s.v0;
        b = s.v1;
        c = s.v2;
        d = s.v3;
        a = a + b;
        c = c + d;
        b = rotl(b, ROT_B1);
        d = rotl(d, ROT_D1);
        b = b ^ a;
        d = d ^ c;
        a = rotl(a, ROT_HALF);
        c = c + b;
        a = a + d;
        b = rotl(b, ROT_B2);
        d = rotl(d, ROT_D2);
        b = b ^ c;
        d = d ^ a;
        c = rotl(c, ROT_HALF);
        sip_round = '{v0: a, v1: b, v2: c, v3: d};
    endfunction

endpackage

/* rtl/sth_pad.sv */
// ----------------------------------------------------------------------------
// sth_pad
// builds the absorbed packet: raw words, or the padded tail of a final packet
// ----------------------------------------------------------------------------
module sth_pad
    import sth_pkg::*;
(
    input  t_packet           i_pkt,
    input  logic              i_is_final,
    input  logic [TAIL_W-1:0] i_tail_bytes,
    output t_packet           o_pkt
);

    logic [PKT_BYTES*8-1:0] src;
    logic [PKT_BYTES*8-1:0] dst;
    logic [TAIL_W-1:0]      whole;

    assign src   = i_pkt;
    assign whole = {i_tail_bytes[TAIL_W-1:2], 2'b00};

    // whole 32-bit words stay, leftover bytes go to 28..30, count in byte 31
    always_comb begin
        logic [TAIL_W-1:0] idx;
        dst = '0;
        for (int i = 0; i < PKT_BYTES - 4; i++) begin
            if (TAIL_W'(i) < whole) begin
                dst[i*8 +: 8] = src[i*8 +: 8];
            end
        end
        for (int j = 0; j < 3; j++) begin
            idx = whole + TAIL_W'(j);
            if (2'(j) < i_tail_bytes[1:0]) begin
                dst[(PKT_BYTES-4+j)*8 +: 8] = src[{idx, 3'b000} +: 8];
            end
        end
        dst[(PKT_BYTES-1)*8 +: 8] = 8'(i_tail_bytes);
    end

    assign o_pkt = i_is_final ? t_packet'(dst) : i_pkt;

endmodule

/* rtl/sth_lane.sv */
// ----------------------------------------------------------------------------
// sth_lane
// one siphash lane: state registers and a single round unit
// ----------------------------------------------------------------------------
module sth_lane
    import sth_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_lane_ctrl i_ctrl,
    input  t_word      i_key,
    input  t_word      i_word,
    output t_word      o_hash
);

    t_word      r_v0, r_v1, r_v2, r_v3;
    t_word      n_v0, n_v1, n_v2, n_v3;
    t_sip_state rnd_in;
    t_sip_state rnd_out;

    // round input, v3 takes the word on the first round of a packet
    always_comb begin
        rnd_in.v0 = r_v0;
        rnd_in.v1 = r_v1;
        rnd_in.v2 = r_v2;
        rnd_in.v3 = i_ctrl.start ? (r_v3 ^ i_word) : r_v3;
    end

    assign rnd_out = sip_round(rnd_in);

    // lane digest of the round output
    assign o_hash = rnd_out.v0 ^ rnd_out.v1 ^ rnd_out.v2 ^ rnd_out.v3;

    // next state
    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_v2 = r_v2;
        n_v3 = r_v3;
        if (i_ctrl.init) begin
            n_v0 = INIT_C0 ^ i_key;
            n_v1 = INIT_C1 ^ i_key;
            n_v2 = INIT_C2 ^ i_key;
            n_v3 = INIT_C3 ^ i_key;
        end else if (i_ctrl.start || i_ctrl.step) begin
            n_v0 = i_ctrl.mix  ? (rnd_out.v0 ^ i_word)     : rnd_out.v0;
            n_v1 = rnd_out.v1;
            n_v2 = i_ctrl.mark ? (rnd_out.v2 ^ FINAL_MARK) : rnd_out.v2;
            n_v3 = rnd_out.v3;
        end
    end

    // state registers, reset loads the keyed constants
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= INIT_C0 ^ i_key;
            r_v1 <= INIT_C1 ^ i_key;
            r_v2 <= INIT_C2 ^ i_key;
            r_v3 <= INIT_C3 ^ i_key;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

endmodule

/* rtl/sth_merge.sv */
// ----------------------------------------------------------------------------
// sth_merge
// gathers the lane digests into the result register and holds it until taken
// ----------------------------------------------------------------------------
module sth_merge
    import sth_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_packet i_hash,
    output logic    o_valid,
    input  logic    i_ready,
    output t_packet o_hash
);

    logic    r_valid;
    logic    n_valid;
    t_packet r_hash;

    // a load only comes when the register is free or being emptied
    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hash <= i_hash;
        end
    end

    assign o_valid = r_valid;
    assign o_hash  = r_hash;

endmodule

/* rtl/sip_tree_hash_core_top.sv */
// ----------------------------------------------------------------------------
// sip_tree_hash_core_top
// four-lane keyed tree hash core, one siphash-2-4 lane per packet word
// ----------------------------------------------------------------------------
//
//  channel   | handshake                | payload
//  ----------+--------------------------+----------------------------------------
//  packet in | i_valid / o_ready        | i_packet_word0..3, i_is_final, i_tail_bytes
//  hash out  | o_valid / i_ready        | o_hash_lane0..3
//  config    | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  each lane has one round unit and runs the two absorb rounds of a packet
//  back to back on its fed-back state
//  a final packet runs the 2 absorb rounds and then 4 finalization rounds
//  and yields one transaction on the hash out channel
//  the last finalization round waits while the result register is still full
//  reset clears the keys and loads every lane from them in the same cycle
//
module sip_tree_hash_core_top
    import sth_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // packet in
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [WORD_W-1:0]    i_packet_word0,
    input  logic [WORD_W-1:0]    i_packet_word1,
    input  logic [WORD_W-1:0]    i_packet_word2,
    input  logic [WORD_W-1:0]    i_packet_word3,
    input  logic                 i_is_final,
    input  logic [TAIL_W-1:0]    i_tail_bytes,
    // hash out
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_W-1:0]    o_hash_lane0,
    output logic [WORD_W-1:0]    o_hash_lane1,
    output logic [WORD_W-1:0]    o_hash_lane2,
    output logic [WORD_W-1:0]    o_hash_lane3,
    // config
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_word               r_key [LANES];
    t_word               n_key [LANES];
    logic                r_busy;
    logic [RND_W-1:0]    r_rnd;
    logic                r_final;
    t_packet             r_word;
    t_packet             in_pkt;
    t_packet             pad_pkt;
    t_packet             lane_hash;
    t_packet             out_hash;
    t_lane_ctrl          ctrl;
    logic                accept;
    logic                cfg_we;
    logic                last;
    logic                step;
    logic                absorb_done;
    logic                out_valid;

    assign in_pkt = {i_packet_word3, i_packet_word2, i_packet_word1, i_packet_word0};

    // padding of the final packet
    sth_pad u_pad (
        .i_pkt        (in_pkt),
        .i_is_final   (i_is_final),
        .i_tail_bytes (i_tail_bytes),
        .o_pkt        (pad_pkt)
    );

    // key registers, only the key word indexes write and reload the lanes
    assign o_cfg_ready = i_rst_n;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_key[i] = r_key[i];
        end
        cfg_we = 1'b0;
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                n_key[i] = '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY_WORD0: begin
                    n_key[0] = i_cfg_data;
                    cfg_we   = 1'b1;
                end
                REG_KEY_WORD1: begin
                    n_key[1] = i_cfg_data;
                    cfg_we   = 1'b1;
                end
                REG_KEY_WORD2: begin
                    n_key[2] = i_cfg_data;
                    cfg_we   = 1'b1;
                end
                REG_KEY_WORD3: begin
                    n_key[3] = i_cfg_data;
                    cfg_we   = 1'b1;
                end
                default: begin
                    cfg_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LANES; i++) begin
            r_key[i] <= n_key[i];
        end
    end

    // round sequencer shared by all lanes
    assign o_ready     = i_rst_n && !r_busy;
    assign accept      = i_valid && o_ready;
    assign last        = r_final && (r_rnd == RND_W'(ABSORB_ROUNDS + FINAL_ROUNDS - 1));
    assign step        = r_busy && !(last && out_valid && !i_ready);
    assign absorb_done = (r_rnd == RND_W'(ABSORB_ROUNDS - 1));

    always_comb begin
        ctrl.init  = cfg_we || (step && last);
        ctrl.start = accept;
        ctrl.step  = step;
        ctrl.mix   = step && absorb_done;
        ctrl.mark  = step && absorb_done && r_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_rnd   <= '0;
            r_final <= 1'b0;
        end else if (accept) begin
            r_busy  <= 1'b1;
            r_rnd   <= RND_W'(1);
            r_final <= i_is_final;
        end else if (step) begin
            if ((absorb_done && !r_final) || last) begin
                r_busy <= 1'b0;
            end else begin
                r_rnd <= r_rnd + RND_W'(1);
            end
        end
    end

    // packet words held for the mix after the second round
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= pad_pkt;
        end
    end

    // lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        sth_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_key   (n_key[g] ^ WORD_W'(KEY_TWEAK_BASE + g)),
            .i_word  (accept ? pad_pkt[g] : r_word[g]),
            .o_hash  (lane_hash[g])
        );
    end

    // result register
    sth_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && last),
        .i_hash  (lane_hash),
        .o_valid (out_valid),
        .i_ready (i_ready),
        .o_hash  (out_hash)
    );

    assign o_valid      = out_valid;
    assign o_hash_lane0 = out_hash[0];
    assign o_hash_lane1 = out_hash[1];
    assign o_hash_lane2 = out_hash[2];
    assign o_hash_lane3 = out_hash[3];

endmodule

/* dv/tb_sip_tree_hash_core_top.sv */
// ----------------------------------------------------------------------------
// tb_sip_tree_hash_core_top
// self-checking bench for the four-lane keyed tree hash core: packets go in
// over a valid/ready channel, per-lane hashes are predicted in the bench and
// compared lane by lane with every hash transaction that comes out
// ----------------------------------------------------------------------------
module tb_sip_tree_hash_core_top
    import sth_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_MAX      = 18;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 400;
    localparam int PRINT_CAP     = 50;

    // clock, reset and block inputs
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [WORD_W-1:0]    i_packet_word0 = '0;
    logic [WORD_W-1:0]    i_packet_word1 = '0;
    logic [WORD_W-1:0]    i_packet_word2 = '0;
    logic [WORD_W-1:0]    i_packet_word3 = '0;
    logic                 i_is_final = 1'b0;
    logic [TAIL_W-1:0]    i_tail_bytes = '0;
    logic                 i_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    // block outputs
    logic                 o_ready;
    logic                 o_valid;
    logic [WORD_W-1:0]    o_hash_lane0;
    logic [WORD_W-1:0]    o_hash_lane1;
    logic [WORD_W-1:0]    o_hash_lane2;
    logic [WORD_W-1:0]    o_hash_lane3;
    logic                 o_cfg_ready;

    // bench-side copy of keys and lane state
    t_word   key_reg [LANES];
    t_word   lane_v0 [LANES];
    t_word   lane_v1 [LANES];
    t_word   lane_v2 [LANES];
    t_word   lane_v3 [LANES];
    t_packet pending_hashes [$];

    // traffic shaping and bookkeeping
    bit snd_idle_on = 1'b1;
    bit rcv_idle_on = 1'b1;
    int rcv_hold_cycles = 0;
    int mismatch_count = 0;
    int packets_sent = 0;
    int hashes_checked = 0;
    int key_writes = 0;
    int stall_cycles = 0;

    sip_tree_hash_core_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_packet_word0 (i_packet_word0),
        .i_packet_word1 (i_packet_word1),
        .i_packet_word2 (i_packet_word2),
        .i_packet_word3 (i_packet_word3),
        .i_is_final     (i_is_final),
        .i_tail_bytes   (i_tail_bytes),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hash_lane0   (o_hash_lane0),
        .o_hash_lane1   (o_hash_lane1),
        .o_hash_lane2   (o_hash_lane2),
        .o_hash_lane3   (o_hash_lane3),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // hash predictor
    // ------------------------------------------------------------------------

    function automatic t_word rot_left(input t_word x, input int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    // run a number of siprounds on one lane
    function automatic void run_rounds(input int lane, input int count);
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        a = lane_v0[lane];
        b = lane_v1[lane];
        c = lane_v2[lane];
        d = lane_v3[lane];
        for (int r = 0; r < count; r++) begin
            a += b;
            c += d;
            b = rot_left(b, 13) ^ a;
            d = rot_left(d, 16) ^ c;
            a = rot_left(a, 32);
            c += b;
            a += d;
            b = rot_left(b, 17) ^ c;
            d = rot_left(d, 21) ^ a;
            c = rot_left(c, 32);
        end
        lane_v0[lane] = a;
        lane_v1[lane] = b;
        lane_v2[lane] = c;
        lane_v3[lane] = d;
    endfunction

    // every lane restarts from its tweaked key
    function automatic void reload_lanes();
        t_word k;
        for (int i = 0; i < LANES; i++) begin
            k = key_reg[i] ^ t_word'(KEY_TWEAK_BASE + i);
            lane_v0[i] = INIT_C0 ^ k;
            lane_v1[i] = INIT_C1 ^ k;
            lane_v2[i] = INIT_C2 ^ k;
            lane_v3[i] = INIT_C3 ^ k;
        end
    endfunction

    // whole 32-bit words stay, leftover bytes go to 28..30, count in byte 31
    function automatic t_packet pad_tail(input t_packet raw, input logic [TAIL_W-1:0] tail);
        logic [7:0] src [32];
        logic [7:0] dst [32];
        int         whole;
        int         rest;
        t_packet    w;
        whole = (int'(tail) >> 2) * 4;
        rest  = int'(tail) & 3;
        for (int i = 0; i < 32; i++) begin
            src[i] = raw[i / 8][(i % 8) * 8 +: 8];
            dst[i] = 8'h00;
        end
        for (int i = 0; i < whole; i++)
            dst[i] = src[i];
        for (int i = 0; i < rest; i++)
            dst[28 + i] = src[whole + i];
        dst[31] = 8'(tail);
        for (int i = 0; i < 32; i++)
            w[i / 8][(i % 8) * 8 +: 8] = dst[i];
        return w;
    endfunction

    function automatic void absorb_words(input t_packet w);
        for (int i = 0; i < LANES; i++) begin
            lane_v3[i] ^= w[i];
            run_rounds(i, ABSORB_ROUNDS);
            lane_v0[i] ^= w[i];
        end
    endfunction

    // update the lane state for one accepted packet, queue the hash if last
    function automatic void predict_packet(input t_packet words, input logic last,
                                           input logic [TAIL_W-1:0] tail);
        t_packet res;
        if (!last) begin
            absorb_words(words);
            return;
        end
        absorb_words(pad_tail(words, tail));
        for (int i = 0; i < LANES; i++) begin
            lane_v2[i] ^= FINAL_MARK;
            run_rounds(i, FINAL_ROUNDS);
            res[i] = lane_v0[i] ^ lane_v1[i] ^ lane_v2[i] ^ lane_v3[i];
        end
        reload_lanes();
        pending_hashes.push_back(res);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // random word, now and then an extreme
    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_packet rand_packet();
        t_packet p;
        for (int i = 0; i < LANES; i++)
            p[i] = rand_word();
        return p;
    endfunction

    // one packet transaction, valid held until accepted
    task automatic offer_packet(input t_packet words, input logic last,
                                input logic [TAIL_W-1:0] tail);
        int gap;
        gap = snd_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_packet_word0 <= words[0];
        i_packet_word1 <= words[1];
        i_packet_word2 <= words[2];
        i_packet_word3 <= words[3];
        i_is_final     <= last;
        i_tail_bytes   <= tail;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        predict_packet(words, last, tail);
        packets_sent++;
    endtask

    // stop sending and wait for every pending hash plus the in-flight packet
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one config transaction, only called with the block idle
    task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input t_word data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < LANES) begin
            key_reg[idx] = data;
            reload_lanes();
        end
        key_writes++;
        @(posedge i_clk);
    endtask

    task automatic write_all_keys(input t_word k0, input t_word k1,
                                  input t_word k2, input t_word k3);
        drain_results();
        write_key(REG_KEY_WORD0, k0);
        write_key(REG_KEY_WORD1, k1);
        write_key(REG_KEY_WORD2, k2);
        write_key(REG_KEY_WORD3, k3);
    endtask

    task automatic flag_mismatch(input string what, input t_word got, input t_word want);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] MISMATCH %s: got %016h want %016h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // field extremes, padding boundaries and the empty message
    task automatic test_directed_padding();
        int tails [14] = '{1, 2, 3, 4, 5, 7, 8, 15, 16, 27, 28, 29, 30, 31};
        // empty message, then tail 0 with junk that must be dropped
        offer_packet('0, 1'b1, '0);
        offer_packet('1, 1'b1, '0);
        // full packets of all ones, tail field ignored when not last
        offer_packet('1, 1'b0, '1);
        offer_packet('1, 1'b1, '1);
        offer_packet('0, 1'b0, '0);
        offer_packet(rand_packet(), 1'b1, TAIL_W'(1));
        // every class of leftover byte count
        foreach (tails[i])
            offer_packet((i % 2) ? '1 : rand_packet(), 1'b1, TAIL_W'(tails[i]));
        // a longer message
        offer_packet(rand_packet(), 1'b0, '0);
        offer_packet(rand_packet(), 1'b0, '0);
        offer_packet(rand_packet(), 1'b1, TAIL_W'(12));
    endtask

    // extreme and random key settings, ignored indexes, abandoned message
    task automatic test_key_settings();
        write_all_keys('1, '1, '1, '1);
        offer_packet(rand_packet(), 1'b1, TAIL_W'(31));
        offer_packet(rand_packet(), 1'b0, '0);
        offer_packet(rand_packet(), 1'b1, TAIL_W'(6));
        write_all_keys(64'h8000_0000_0000_0000, 64'h1, '1, '0);
        offer_packet('1, 1'b1, TAIL_W'(17));
        offer_packet(rand_packet(), 1'b1, '0);
        write_all_keys(rand_word(), rand_word(), rand_word(), rand_word());
        offer_packet(rand_packet(), 1'b1, TAIL_W'(9));
        // indexes past the key list change nothing
        drain_results();
        write_key(CFG_IDX_W'(LANES), '1);
        write_key('1, 64'h5a5a_5a5a_5a5a_5a5a);
        offer_packet(rand_packet(), 1'b1, TAIL_W'(22));
        // key write in the middle of a message restarts all lanes
        offer_packet(rand_packet(), 1'b0, '0);
        offer_packet(rand_packet(), 1'b0, '0);
        drain_results();
        write_key(REG_KEY_WORD1, rand_word());
        offer_packet(rand_packet(), 1'b1, TAIL_W'(3));
        write_all_keys('0, '0, '0, '0);
    endtask

    // phase boundary: maybe leave a message open, then new keys and idling
    task automatic change_phase();
        int n_writes;
        logic [CFG_IDX_W-1:0] idx;
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) offer_packet(rand_packet(), 1'b0, TAIL_W'($urandom));
        drain_results();
        n_writes = $urandom_range(1, 4);
        repeat (n_writes) begin
            if ($urandom_range(0, 7) == 0)
                idx = CFG_IDX_W'($urandom_range(LANES, 255));
            else
                idx = CFG_IDX_W'($urandom_range(0, LANES - 1));
            write_key(idx, rand_word());
        end
        snd_idle_on = ($urandom_range(0, 3) != 0);
        rcv_idle_on = ($urandom_range(0, 3) != 0);
    endtask

    // well-formed messages of random length and content
    task automatic test_random_messages(input int target);
        int first;
        int n_full;
        first = packets_sent;
        while (packets_sent - first < target) begin
            if ($urandom_range(0, 59) == 0)
                change_phase();
            n_full = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 16)
                                                  : $urandom_range(0, 5);
            for (int p = 0; p < n_full; p++) begin
                offer_packet(rand_packet(), 1'b0, TAIL_W'($urandom));
                // sender pauses inside a message until the output is empty
                if (p == 0 && $urandom_range(0, 24) == 0)
                    drain_results();
            end
            offer_packet(rand_packet(), 1'b1, TAIL_W'($urandom));
        end
        snd_idle_on = 1'b1;
        rcv_idle_on = 1'b1;
    endtask

    // receiver holds off while short messages keep coming back to back
    task automatic test_backpressure();
        drain_results();
        snd_idle_on = 1'b0;
        rcv_hold_cycles = LONG_HOLD;
        repeat (16) offer_packet(rand_packet(), 1'b1, TAIL_W'($urandom));
        drain_results();
        snd_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, one long hold on request
    // ------------------------------------------------------------------------
    initial begin : hash_receiver
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rcv_hold_cycles > 0) begin
                stall = rcv_hold_cycles;
                rcv_hold_cycles = 0;
            end else begin
                stall = rcv_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // ------------------------------------------------------------------------
    // hash checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : hash_check
        t_packet got;
        t_packet want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_hash_lane3, o_hash_lane2, o_hash_lane1, o_hash_lane0};
            if (pending_hashes.size() == 0) begin
                flag_mismatch("hash transaction with none pending", got[0], '0);
            end else begin
                want = pending_hashes.pop_front();
                for (int i = 0; i < LANES; i++)
                    if (got[i] !== want[i])
                        flag_mismatch($sformatf("hash_lane%0d", i), got[i], want[i]);
                hashes_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no transaction on any channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] timeout: no transaction for %0d cycles, %0d hashes pending",
                         $realtime, stall_cycles, pending_hashes.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < LANES; i++)
            key_reg[i] = '0;
        reload_lanes();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_padding();
        test_key_settings();
        test_backpressure();
        test_random_messages(2000);
        test_backpressure();
        drain_results();

        $display("covered %0d packets and %0d key writes over all tail lengths,",
                 packets_sent, key_writes);
        $display("key extremes, ignored indexes and output hold-off; %0d hashes checked",
                 hashes_checked);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/sth_pkg.sv
rtl/sth_pad.sv
rtl/sth_lane.sv
rtl/sth_merge.sv
rtl/sip_tree_hash_core_top.sv
dv/tb_sip_tree_hash_core_top.sv
